// ===== sv/rhsv_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
`default_nettype none
package rhsv_pkg;

   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned DIV_STEPS  = CHAN_W;   // one quotient bit per cell
   localparam int unsigned PROD_W     = 2 * CHAN_W;

   localparam logic [CHAN_W-1:0] HUE_OFFSET_RED   = 8'd0;
   localparam logic [CHAN_W-1:0] HUE_OFFSET_GREEN = 8'd85;
   localparam logic [CHAN_W-1:0] HUE_OFFSET_BLUE  = 8'd171;

   // One pipeline slot: two restoring dividers running side by side plus
   // the fields that ride along to the output stage.
   typedef struct packed {
      logic              valid;
      logic              gray;      // max equals min (includes black)
      logic [CHAN_W-1:0] sat_rem;
      logic [CHAN_W-1:0] sat_num;   // numerator bits not yet shifted in
      logic [CHAN_W-1:0] sat_den;
      logic [CHAN_W-1:0] sat_quo;
      logic [CHAN_W-1:0] hue_rem;
      logic [CHAN_W-1:0] hue_num;
      logic [CHAN_W-1:0] hue_den;
      logic [CHAN_W-1:0] hue_quo;
      logic              hue_neg;
      logic [CHAN_W-1:0] hue_offset;
      logic [CHAN_W-1:0] bright;
   } stage_type;

endpackage
`default_nettype wire

// ===== sv/rhsv_front.sv =====
// Front cell: max/min search, sector select and divider numerators.
`default_nettype none
module rhsv_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic                      in_valid,
   input  wire logic [rhsv_pkg::CHAN_W-1:0] red,
   input  wire logic [rhsv_pkg::CHAN_W-1:0] green,
   input  wire logic [rhsv_pkg::CHAN_W-1:0] blue,
   output rhsv_pkg::stage_type            stage_out
);

   rhsv_pkg::stage_type stage_ff, stage_in;

   logic [rhsv_pkg::CHAN_W-1:0] mx, mn, span, mag;
   logic signed [rhsv_pkg::CHAN_W:0] diff;
   logic [rhsv_pkg::PROD_W-1:0] sat_prod, hue_prod, mag_wide;

   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      span = mx - mn;

      // sector priority on ties: red, then green, then blue
      priority if (mx == red) begin
         stage_in.hue_offset = rhsv_pkg::HUE_OFFSET_RED;
         diff = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (mx == green) begin
         stage_in.hue_offset = rhsv_pkg::HUE_OFFSET_GREEN;
         diff = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         stage_in.hue_offset = rhsv_pkg::HUE_OFFSET_BLUE;
         diff = $signed({1'b0, red}) - $signed({1'b0, green});
      end

      mag = diff[rhsv_pkg::CHAN_W] ? rhsv_pkg::CHAN_W'(-diff)
                                   : diff[rhsv_pkg::CHAN_W-1:0];
      mag_wide = rhsv_pkg::PROD_W'(mag);
      // 255*span and 43*|diff| by shift and add
      sat_prod = {span, {rhsv_pkg::CHAN_W{1'b0}}} - rhsv_pkg::PROD_W'(span);
      hue_prod = (mag_wide << 5) + (mag_wide << 3) + (mag_wide << 1) + mag_wide;

      stage_in.valid   = in_valid;
      stage_in.gray    = (span == '0);
      stage_in.sat_rem = sat_prod[rhsv_pkg::PROD_W-1:rhsv_pkg::CHAN_W];
      stage_in.sat_num = sat_prod[rhsv_pkg::CHAN_W-1:0];
      stage_in.sat_den = mx;
      stage_in.sat_quo = '0;
      stage_in.hue_rem = hue_prod[rhsv_pkg::PROD_W-1:rhsv_pkg::CHAN_W];
      stage_in.hue_num = hue_prod[rhsv_pkg::CHAN_W-1:0];
      stage_in.hue_den = span;
      stage_in.hue_quo = '0;
      stage_in.hue_neg = diff[rhsv_pkg::CHAN_W];
      stage_in.bright  = mx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

// ===== sv/rhsv_div_cell.sv =====
// Divider cell: one restoring step for both the saturation and hue quotients.
`default_nettype none
module rhsv_div_cell (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire rhsv_pkg::stage_type stage_in_port,
   output rhsv_pkg::stage_type stage_out
);

   rhsv_pkg::stage_type stage_ff, stage_in;

   logic [rhsv_pkg::CHAN_W:0] sat_t, sat_d, hue_t, hue_d;
   logic                      sat_ge, hue_ge;

   always_comb begin
      stage_in = stage_in_port;

      // remainder stays below the divisor, so the trial value fits 9 bits
      sat_t  = {stage_in_port.sat_rem, stage_in_port.sat_num[rhsv_pkg::CHAN_W-1]};
      sat_d  = sat_t - {1'b0, stage_in_port.sat_den};
      sat_ge = (sat_t >= {1'b0, stage_in_port.sat_den});
      stage_in.sat_rem = sat_ge ? sat_d[rhsv_pkg::CHAN_W-1:0]
                                : sat_t[rhsv_pkg::CHAN_W-1:0];
      stage_in.sat_num = {stage_in_port.sat_num[rhsv_pkg::CHAN_W-2:0], 1'b0};
      stage_in.sat_quo = {stage_in_port.sat_quo[rhsv_pkg::CHAN_W-2:0], sat_ge};

      hue_t  = {stage_in_port.hue_rem, stage_in_port.hue_num[rhsv_pkg::CHAN_W-1]};
      hue_d  = hue_t - {1'b0, stage_in_port.hue_den};
      hue_ge = (hue_t >= {1'b0, stage_in_port.hue_den});
      stage_in.hue_rem = hue_ge ? hue_d[rhsv_pkg::CHAN_W-1:0]
                                : hue_t[rhsv_pkg::CHAN_W-1:0];
      stage_in.hue_num = {stage_in_port.hue_num[rhsv_pkg::CHAN_W-2:0], 1'b0};
      stage_in.hue_quo = {stage_in_port.hue_quo[rhsv_pkg::CHAN_W-2:0], hue_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

// ===== sv/rgb_to_hsv_8bit.sv =====
// Top level of the pipelined 8-bit RGB to HSV converter.
//
// Usage:
//   req_ channel carries one pixel per transfer: red, green, blue in tdata.
//   rsp_ channel returns one HSV result per pixel, in order: hue,
//   saturation, brightness (the channel maximum) in tdata.
//   Throughput: one pixel per clock cycle, sustained while rsp_tready stays high.
//   Path: the front cell (max/min, sector, numerators) loads at the
//   req_ transfer edge, then the pixel passes eight divider cells that
//   each settle one quotient bit of both the saturation and the hue
//   divisions, and then the output register that applies sign, sector
//   offset and the gray/black overrides and drives rsp_tvalid.
//   The whole chain moves together. It advances whenever the output
//   register is empty or its result is taken in the same cycle, so
//   req_tready is high while rsp_tready is high or rsp_ holds no result.
//   When the receiver stalls with a result waiting, the chain freezes and
//   req_tready drops; pixels already inside are held, none are lost.
//   Reset clears every valid flag; the block keeps no other state and
//   accepts pixels in the first cycle after reset is released.
`default_nettype none
module rgb_to_hsv_8bit (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: [7:0] red, [15:8] green, [23:16] blue
   input  wire logic [23:0] req_tdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata: [7:0] hue, [15:8] saturation, [23:16] brightness
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready
);

   localparam int unsigned W = rhsv_pkg::CHAN_W;

   logic advance;
   rhsv_pkg::stage_type chain [rhsv_pkg::DIV_STEPS+1];
   logic [rhsv_pkg::DIV_STEPS:0] chain_valid;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [3*W-1:0]  rsp_data_ff, rsp_data_in;
   logic [W-1:0]    hue_val;

   // whole chain steps when the output slot is free or being emptied
   assign advance    = rsp_tready || !rsp_valid_ff;
   assign req_tready = advance;

   rhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .red       (req_tdata[W-1:0]),
      .green     (req_tdata[2*W-1:W]),
      .blue      (req_tdata[3*W-1:2*W]),
      .stage_out (chain[0])
   );

   for (genvar i = 0; i < rhsv_pkg::DIV_STEPS; i++) begin : g_cell
      rhsv_div_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .stage_in_port (chain[i]),
         .stage_out     (chain[i+1])
      );
   end

   for (genvar j = 0; j <= rhsv_pkg::DIV_STEPS; j++) begin : g_valid
      assign chain_valid[j] = chain[j].valid;
   end

   // output stage: signed quotient plus sector offset, wraps mod 256
   always_comb begin
      hue_val = chain[rhsv_pkg::DIV_STEPS].hue_neg
              ? chain[rhsv_pkg::DIV_STEPS].hue_offset - chain[rhsv_pkg::DIV_STEPS].hue_quo
              : chain[rhsv_pkg::DIV_STEPS].hue_offset + chain[rhsv_pkg::DIV_STEPS].hue_quo;
      rsp_valid_in = chain[rhsv_pkg::DIV_STEPS].valid;
      // gray or black: no hue, no saturation
      if (chain[rhsv_pkg::DIV_STEPS].gray) begin
         rsp_data_in = {chain[rhsv_pkg::DIV_STEPS].bright, {W{1'b0}}, {W{1'b0}}};
      end else begin
         rsp_data_in = {chain[rhsv_pkg::DIV_STEPS].bright,
                        chain[rhsv_pkg::DIV_STEPS].sat_quo, hue_val};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // chain holds every slot while the receiver stalls
   a_frozen_chain: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chain_valid))
      else $error("pipeline valid flags moved during a stall");

   // zero saturation always means zero hue
   a_gray_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2*W-1:W] == '0) |-> (rsp_tdata[W-1:0] == '0))
      else $error("hue nonzero with zero saturation");

   // black pixel has zero saturation
   a_black_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3*W-1:2*W] == '0) |-> (rsp_tdata[2*W-1:W] == '0))
      else $error("saturation nonzero for black pixel");

   // reset empties the output slot
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire
